// ----- hdl/bam_pkg.sv -----
// Package for the block allocation bitmap.
// Holds field widths, command and status codes and the word types.
// Depends on nothing; every other file imports it.
`default_nettype none

package bam_pkg;

  // Field widths of the input and result words.
  localparam int unsigned BLK_W = 6;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned OCC_W = 32;
  localparam int unsigned MAP_MAX = 64;

  // Default number of blocks in the map.
  localparam int unsigned NUM_BLOCKS_DEF = 32;

  typedef enum logic {
    CMD_RANGE = 1'b0,
    CMD_LIST  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_OCCUPIED     = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  // One input word.
  typedef struct packed {
    cmd_t             command;
    logic [BLK_W-1:0] block;
    logic [CNT_W-1:0] count;
    logic             last;
  } item_t;

  // One result word.
  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] fault_block;
    logic [OCC_W-1:0] occupancy;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/bam_in_stage.sv -----
// Input register of the block allocation bitmap.
// Captures one input word and holds it until the core consumes it.
// Depends on bam_pkg.
`default_nettype none

module bam_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  bam_pkg::item_t     up_item,
  output logic               item_valid,
  output bam_pkg::item_t     item,
  input  wire logic          take
);
  import bam_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The register is free when empty or when its word is consumed in the same cycle.
  assign up_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Payload, no reset needed.
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bam_core.sv -----
// Allocation core: committed map, open list claim state and result logic.
// Checks one registered word per cycle while a result slot is free, and updates the map on commit.
// Depends on bam_pkg.
`default_nettype none

module bam_core #(
  parameter int unsigned NUM_BLOCKS = bam_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_valid,
  input  bam_pkg::item_t            item,
  output logic                      take,
  input  wire logic                 res_ready,
  output logic                      res_valid,
  output bam_pkg::result_t          res,
  output logic [NUM_BLOCKS-1:0]     used_map
);
  import bam_pkg::*;

  localparam int unsigned SUM_W = BLK_W + 1;

  logic [NUM_BLOCKS-1:0] used_r, used_nxt;
  logic [NUM_BLOCKS-1:0] pend_map_r, pend_map_nxt;
  status_t               pend_st_r, pend_st_nxt;
  logic [BLK_W-1:0]      pend_fault_r, pend_fault_nxt;

  logic [SUM_W-1:0]   range_end;
  logic               no_space;
  logic [MAP_MAX-1:0] used_wide;
  logic [MAP_MAX-1:0] range_mask;
  logic [MAP_MAX-1:0] hit;
  logic [MAP_MAX-1:0] hit_low;
  logic [BLK_W-1:0]   hit_idx;
  logic [MAP_MAX-1:0] blk_bit;
  logic               blk_oor;

  assign used_map  = used_r;
  assign used_wide = MAP_MAX'(used_r);

  // A word is consumed only when a result slot is free downstream.
  assign take      = item_valid && res_ready;
  assign res_valid = take && ((item.command == CMD_RANGE) || item.last);

  // Range check: end past the map, and the lowest busy block in the range.
  assign range_end  = SUM_W'(item.block) + SUM_W'(item.count);
  assign no_space   = range_end > SUM_W'(NUM_BLOCKS);
  assign range_mask = ((MAP_MAX'(1) << item.count) - MAP_MAX'(1)) << item.block;
  assign hit        = used_wide & range_mask;
  assign hit_low    = hit & (~hit + MAP_MAX'(1));

  // Encode the isolated lowest hit bit.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAP_MAX; i++) begin
      if (hit_low[i]) begin
        hit_idx = hit_idx | BLK_W'(i);
      end
    end
  end

  // List element checks.
  assign blk_bit = MAP_MAX'(1) << item.block;
  assign blk_oor = SUM_W'(item.block) >= SUM_W'(NUM_BLOCKS);

  // Next state and result word.
  always_comb begin
    used_nxt        = used_r;
    pend_map_nxt    = pend_map_r;
    pend_st_nxt     = pend_st_r;
    pend_fault_nxt  = pend_fault_r;
    res.status      = ST_OK;
    res.fault_block = '0;
    if (take) begin
      if (item.command == CMD_RANGE) begin
        // A range claim drops any open list claim.
        pend_map_nxt   = '0;
        pend_st_nxt    = ST_OK;
        pend_fault_nxt = '0;
        if (no_space) begin
          res.status = ST_NO_SPACE;
        end else if (hit != '0) begin
          res.status      = ST_OCCUPIED;
          res.fault_block = hit_idx;
        end else begin
          used_nxt = used_r | range_mask[NUM_BLOCKS-1:0];
        end
      end else begin
        // Only the first failure of a list is kept.
        if (pend_st_r == ST_OK) begin
          if (blk_oor) begin
            pend_st_nxt    = ST_OUT_OF_RANGE;
            pend_fault_nxt = item.block;
          end else if ((used_wide & blk_bit) != '0) begin
            pend_st_nxt    = ST_OCCUPIED;
            pend_fault_nxt = item.block;
          end else begin
            pend_map_nxt = pend_map_r | blk_bit[NUM_BLOCKS-1:0];
          end
        end
        // The last element commits all blocks or none.
        if (item.last) begin
          if (pend_st_nxt == ST_OK) begin
            used_nxt = used_r | pend_map_nxt;
          end
          res.status      = pend_st_nxt;
          res.fault_block = pend_fault_nxt;
          pend_map_nxt    = '0;
          pend_st_nxt     = ST_OK;
          pend_fault_nxt  = '0;
        end
      end
    end
    // The result shows the map as it stands after this claim.
    res.occupancy = OCC_W'(MAP_MAX'(used_nxt));
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      pend_map_r   <= '0;
      pend_st_r    <= ST_OK;
      pend_fault_r <= '0;
    end else begin
      used_r       <= used_nxt;
      pend_map_r   <= pend_map_nxt;
      pend_st_r    <= pend_st_nxt;
      pend_fault_r <= pend_fault_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bam_out_stage.sv -----
// Result register of the block allocation bitmap.
// Holds one result word until the receiver takes it.
// Depends on bam_pkg.
`default_nettype none

module bam_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  output logic               res_ready,
  input  bam_pkg::result_t   res,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output bam_pkg::result_t   dn_res
);
  import bam_pkg::*;

  logic    valid_r;
  result_t res_r;

  // The slot is free when empty or being emptied this cycle.
  assign res_ready = !valid_r || dn_ready;
  assign dn_valid  = valid_r;
  assign dn_res    = res_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  // Payload, no reset needed.
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/block_allocation_bitmap.sv -----
// Block allocation bitmap: keeps an occupancy map of storage blocks.
// Input channel (in_*): one word per range claim or per list element.
// A range claim (command 0) marks blocks block .. block+count-1, or fails
// with no space or with the lowest occupied block. A list claim (command 1)
// sends one block per word; the word with last set closes it, and then all
// listed blocks are marked together or none is.
// Output channel (out_*): one word per range claim and per closing list
// element, with status, fault block and the occupancy map after the claim.
// The input register captures an accepted word, the core checks it, and the
// result register captures the result word and raises out_valid. Throughput
// is one word per cycle while the receiver does not stall, set by the
// combinational check and update of the map between those two registers.
// Reset (rst_n low, synchronous) frees all blocks and drops any open list.
// When the receiver stalls, the result register holds its word and the
// input register fills next; in_ready then drops until out_ready returns.
`default_nettype none

module block_allocation_bitmap #(
  parameter int unsigned NUM_BLOCKS = bam_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_command,
  input  wire logic [bam_pkg::BLK_W-1:0]   in_block,
  input  wire logic [bam_pkg::CNT_W-1:0]   in_count,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [bam_pkg::BLK_W-1:0]        out_fault_block,
  output logic [bam_pkg::OCC_W-1:0]        out_occupancy
);
  import bam_pkg::*;

  item_t                 up_item;
  item_t                 item;
  logic                  item_valid;
  logic                  take;
  logic                  res_ready;
  logic                  res_valid;
  result_t               res;
  result_t               dn_res;
  logic [NUM_BLOCKS-1:0] used_map;

  // Pack the input word.
  assign up_item.command = cmd_t'(in_command);
  assign up_item.block   = in_block;
  assign up_item.count   = in_count;
  assign up_item.last    = in_last;

  bam_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_item    (up_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  bam_core #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .used_map   (used_map)
  );

  bam_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .dn_valid   (out_valid),
    .dn_ready   (out_ready),
    .dn_res     (dn_res)
  );

  // Unpack the result word.
  assign out_status      = dn_res.status;
  assign out_fault_block = dn_res.fault_block;
  assign out_occupancy   = dn_res.occupancy;

  // A successful claim and a no-space failure report no fault block.
  a_ok_no_fault : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK || out_status == ST_NO_SPACE))
      |-> (out_fault_block == '0))
    else $error("fault block set on a result that names none");

  // Blocks once marked stay marked until reset.
  a_map_grows : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((used_map & $past(used_map)) == $past(used_map)))
    else $error("occupied block was freed");

  // Input backpressure only comes from a held result.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

`default_nettype wire
